[hdl/mdc_pkg.sv]
// Package for the multichannel DMA controller: types, command codes and constants.
// No dependencies.
package mdc_pkg;

    localparam int NUM_CHANNELS_DEF = 12;
    localparam logic [31:0] COUNT_LIMIT = 32'h0020_0000;
    localparam int BUSY_BIT = 24;
    localparam logic [5:0] REQ_SPI_TX = 6'd18;
    localparam logic [5:0] REQ_SPI_RX = 6'd19;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PASS  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Global register offsets
    localparam logic [13:0] OFF_STATUS = 14'h400;
    localparam logic [13:0] OFF_EN0    = 14'h404;
    localparam logic [13:0] OFF_FRC0   = 14'h408;
    localparam logic [13:0] OFF_MSK0   = 14'h40C;
    localparam logic [13:0] OFF_EN1    = 14'h414;
    localparam logic [13:0] OFF_FRC1   = 14'h418;
    localparam logic [13:0] OFF_MSK1   = 14'h41C;
    localparam logic [13:0] OFF_MULTI  = 14'h430;
    localparam logic [13:0] OFF_SNIFF0 = 14'h434;
    localparam logic [13:0] OFF_SNIFF1 = 14'h438;
    localparam logic [13:0] OFF_ABORT  = 14'h444;

    // Queued command between front and back
    typedef struct packed {
        cmd_t        cmd;
        logic [13:0] offset;
        logic [31:0] wdata;
        logic        tx_ok;
        logic        rx_ok;
    } cmd_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULTI,
        ST_PASS,
        ST_OUT
    } back_state_t;

endpackage

[hdl/mdc_cmd_fifo.sv]
// Two-entry command queue between the front and back parts.
// Depends on mdc_pkg.
module mdc_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mdc_pkg::cmd_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output mdc_pkg::cmd_item_t out_item
);
    import mdc_pkg::*;

    cmd_item_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (out_valid && out_ready)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
        end
    end
endmodule

[hdl/mdc_engine.sv]
// Back part: channel register file, trigger/chain logic and the service-pass walker.
// Depends on mdc_pkg.
module mdc_engine #(
    parameter int NUM_CHANNELS = mdc_pkg::NUM_CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mdc_pkg::cmd_item_t cmd_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        read_data,
    output logic               xfer_valid,
    output logic [3:0]         xfer_channel,
    output logic [31:0]        xfer_source,
    output logic [31:0]        xfer_dest,
    output logic [1:0]         xfer_size_code,
    output logic               irq_line0,
    output logic               irq_line1,
    output logic               last
);
    import mdc_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [13:0] CHAN_SPAN = 14'(NUM_CHANNELS * 64);

    logic [31:0] src_reg  [NUM_CHANNELS];
    logic [31:0] dst_reg  [NUM_CHANNELS];
    logic [31:0] load_reg [NUM_CHANNELS];
    logic [31:0] ctl_reg  [NUM_CHANNELS];
    logic [31:0] left_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] busy_reg;
    logic [NUM_CHANNELS-1:0] irq_reg;
    logic [31:0] en0_reg, frc0_reg, en1_reg, frc1_reg, snf0_reg, snf1_reg;

    back_state_t state_reg, state_next;
    cmd_item_t   item_reg;
    logic [CW-1:0] ch_reg;
    logic        any_reg;

    // Output register
    logic        ov_reg;
    logic [31:0] rd_reg, osrc_reg, odst_reg;
    logic        oxv_reg, olast_reg;
    logic [3:0]  och_reg;
    logic [1:0]  ocode_reg;
    logic        oirq0_reg, oirq1_reg;

    logic out_free;
    assign out_free  = !ov_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE);

    logic [31:0] irq_ext;
    assign irq_ext   = 32'(irq_reg);
    // Interrupt lines travel with the word they belong to
    assign irq_line0 = oirq0_reg;
    assign irq_line1 = oirq1_reg;

    assign out_valid      = ov_reg;
    assign read_data      = rd_reg;
    assign xfer_valid     = oxv_reg;
    assign xfer_channel   = och_reg;
    assign xfer_source    = osrc_reg;
    assign xfer_dest      = odst_reg;
    assign xfer_size_code = ocode_reg;
    assign last           = olast_reg;

    // Decode of the queued command
    logic          in_chan;
    logic [CW-1:0] dch;
    logic [5:0]    dword;
    assign in_chan = cmd_item.offset < CHAN_SPAN;
    assign dch     = CW'(cmd_item.offset[13:6]);
    assign dword   = cmd_item.offset[5:0];

    logic [31:0] rd_val;
    always_comb
    begin
        rd_val = 32'd0;
        if (in_chan)
        begin
            case (dword)
                6'h00, 6'h14, 6'h28, 6'h3C: rd_val = src_reg[dch];
                6'h04, 6'h18, 6'h2C, 6'h34: rd_val = dst_reg[dch];
                6'h08, 6'h1C, 6'h24, 6'h38: rd_val = left_reg[dch];
                6'h0C, 6'h10, 6'h20, 6'h30:
                    rd_val = ctl_reg[dch] | (32'(busy_reg[dch]) << BUSY_BIT);
                default: rd_val = 32'd0;
            endcase
        end
        else
        begin
            case (cmd_item.offset)
                OFF_STATUS: rd_val = irq_ext;
                OFF_EN0:    rd_val = en0_reg;
                OFF_FRC0:   rd_val = frc0_reg;
                OFF_MSK0:   rd_val = (irq_ext & en0_reg) | frc0_reg;
                OFF_EN1:    rd_val = en1_reg;
                OFF_FRC1:   rd_val = frc1_reg;
                OFF_MSK1:   rd_val = (irq_ext & en1_reg) | frc1_reg;
                OFF_SNIFF0: rd_val = snf0_reg;
                OFF_SNIFF1: rd_val = snf1_reg;
                default:    rd_val = 32'd0;
            endcase
        end
    end

    // Service-pass candidate for the current channel
    logic [31:0] cctl;
    logic [5:0]  creq;
    logic        cgo;
    logic [1:0]  ccode;
    logic [31:0] cstep;
    assign cctl  = ctl_reg[ch_reg];
    assign creq  = cctl[20:15];
    assign cgo   = busy_reg[ch_reg]
                   && !(creq == REQ_SPI_TX && !item_reg.tx_ok)
                   && !(creq == REQ_SPI_RX && !item_reg.rx_ok);
    assign ccode = (cctl[3:2] == 2'd3) ? 2'd2 : cctl[3:2];
    assign cstep = 32'd1 << ccode;

    logic ch_is_last;
    assign ch_is_last = (ch_reg == CW'(NUM_CHANNELS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    if (cmd_item.cmd == CMD_PASS)
                        state_next = ST_PASS;
                    else if (cmd_item.cmd == CMD_WRITE && !in_chan
                             && cmd_item.offset == OFF_MULTI)
                        state_next = ST_MULTI;
                    else
                        state_next = ST_OUT;
                end
            ST_MULTI:
                if (ch_is_last) state_next = ST_OUT;
            ST_PASS:
                if (out_free && ch_is_last)
                    state_next = (cgo || any_reg) ? ST_IDLE : ST_OUT;
            ST_OUT:
                if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Arm helper: applied to channel c on the given state; mutates next arrays
    logic [31:0] left_n [NUM_CHANNELS];
    logic [31:0] load_n [NUM_CHANNELS];
    logic [31:0] src_n  [NUM_CHANNELS];
    logic [31:0] dst_n  [NUM_CHANNELS];
    logic [31:0] ctl_n  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] busy_n, irq_n;
    logic [31:0] en0_n, frc0_n, en1_n, frc1_n, snf0_n, snf1_n;
    logic        emit_x;

    // Completion of channel c with chaining
    function automatic void finish_ch(input logic [CW-1:0] c,
                                      inout logic [NUM_CHANNELS-1:0] b,
                                      inout logic [NUM_CHANNELS-1:0] q,
                                      inout logic [31:0] ld [NUM_CHANNELS],
                                      inout logic [31:0] lf [NUM_CHANNELS],
                                      input logic [31:0] ct [NUM_CHANNELS]);
        logic [3:0] t;
        t = ct[c][14:11];
        b[c] = 1'b0;
        ld[c] = 32'd0;
        q[c] = 1'b1;
        if (t != 4'(c) && int'(t) < NUM_CHANNELS)
        begin
            if (ct[CW'(t)][0])
            begin
                lf[CW'(t)] = ld[CW'(t)];
                b[CW'(t)] = ld[CW'(t)] != 32'd0;
            end
        end
    endfunction

    function automatic void arm_ch(input logic [CW-1:0] c,
                                   inout logic [NUM_CHANNELS-1:0] b,
                                   inout logic [NUM_CHANNELS-1:0] q,
                                   inout logic [31:0] ld [NUM_CHANNELS],
                                   inout logic [31:0] lf [NUM_CHANNELS],
                                   input logic [31:0] ct [NUM_CHANNELS]);
        if (ct[c][0] && ld[c] <= COUNT_LIMIT)
        begin
            lf[c] = ld[c];
            b[c] = ld[c] != 32'd0;
            if (ld[c] == 32'd0)
                finish_ch(c, b, q, ld, lf, ct);
        end
    endfunction

    always_comb
    begin
        left_n = left_reg;
        load_n = load_reg;
        src_n  = src_reg;
        dst_n  = dst_reg;
        ctl_n  = ctl_reg;
        busy_n = busy_reg;
        irq_n  = irq_reg;
        en0_n  = en0_reg;
        frc0_n = frc0_reg;
        en1_n  = en1_reg;
        frc1_n = frc1_reg;
        snf0_n = snf0_reg;
        snf1_n = snf1_reg;
        emit_x = 1'b0;
        if (state_reg == ST_IDLE && cmd_valid && cmd_item.cmd == CMD_WRITE)
        begin
            if (in_chan)
            begin
                case (dword)
                    6'h00, 6'h14, 6'h28, 6'h3C: src_n[dch]  = cmd_item.wdata;
                    6'h04, 6'h18, 6'h2C, 6'h34: dst_n[dch]  = cmd_item.wdata;
                    6'h08, 6'h1C, 6'h24, 6'h38: load_n[dch] = cmd_item.wdata;
                    6'h0C, 6'h10, 6'h20, 6'h30: ctl_n[dch]  = cmd_item.wdata;
                    default: ;
                endcase
                if (dword == 6'h0C || dword == 6'h1C || dword == 6'h2C || dword == 6'h3C)
                    arm_ch(dch, busy_n, irq_n, load_n, left_n, ctl_n);
            end
            else
            begin
                case (cmd_item.offset)
                    OFF_STATUS, OFF_MSK0, OFF_MSK1:
                        irq_n = irq_reg & ~cmd_item.wdata[NUM_CHANNELS-1:0];
                    OFF_EN0:    en0_n  = cmd_item.wdata;
                    OFF_FRC0:   frc0_n = cmd_item.wdata;
                    OFF_EN1:    en1_n  = cmd_item.wdata;
                    OFF_FRC1:   frc1_n = cmd_item.wdata;
                    OFF_SNIFF0: snf0_n = cmd_item.wdata;
                    OFF_SNIFF1: snf1_n = cmd_item.wdata;
                    OFF_ABORT:
                        for (int i = 0; i < NUM_CHANNELS; i++)
                        begin
                            if (cmd_item.wdata[i])
                            begin
                                busy_n[i] = 1'b0;
                                left_n[i] = 32'd0;
                            end
                        end
                    default: ;
                endcase
            end
        end
        else if (state_reg == ST_MULTI)
        begin
            // One channel of a multi-channel trigger per cycle
            if (item_reg.wdata[ch_reg])
                arm_ch(ch_reg, busy_n, irq_n, load_n, left_n, ctl_n);
        end
        else if (state_reg == ST_PASS && out_free && cgo)
        begin
            emit_x = 1'b1;
            if (cctl[4]) src_n[ch_reg] = src_reg[ch_reg] + cstep;
            if (cctl[5]) dst_n[ch_reg] = dst_reg[ch_reg] + cstep;
            left_n[ch_reg] = left_reg[ch_reg] - 32'd1;
            if (left_reg[ch_reg] == 32'd1)
                finish_ch(ch_reg, busy_n, irq_n, load_n, left_n, ctl_n);
        end
    end

    // Look ahead: will a later channel of this pass still move a word
    logic more_after;
    always_comb
    begin
        more_after = 1'b0;
        for (int j = 0; j < NUM_CHANNELS; j++)
        begin
            if (j > int'(ch_reg) && busy_n[j]
                && !(ctl_reg[j][20:15] == REQ_SPI_TX && !item_reg.tx_ok)
                && !(ctl_reg[j][20:15] == REQ_SPI_RX && !item_reg.rx_ok))
                more_after = 1'b1;
        end
    end

    // Channel and global state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                src_reg[i]  <= 32'd0;
                dst_reg[i]  <= 32'd0;
                load_reg[i] <= 32'd0;
                ctl_reg[i]  <= 32'd0;
                left_reg[i] <= 32'd0;
            end
            busy_reg <= '0;
            irq_reg  <= '0;
            en0_reg  <= 32'd0;
            frc0_reg <= 32'd0;
            en1_reg  <= 32'd0;
            frc1_reg <= 32'd0;
            snf0_reg <= 32'd0;
            snf1_reg <= 32'd0;
        end
        else
        begin
            src_reg  <= src_n;
            dst_reg  <= dst_n;
            load_reg <= load_n;
            ctl_reg  <= ctl_n;
            left_reg <= left_n;
            busy_reg <= busy_n;
            irq_reg  <= irq_n;
            en0_reg  <= en0_n;
            frc0_reg <= frc0_n;
            en1_reg  <= en1_n;
            frc1_reg <= frc1_n;
            snf0_reg <= snf0_n;
            snf1_reg <= snf1_n;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                ch_reg  <= '0;
                any_reg <= 1'b0;
            end
            else if (state_reg == ST_MULTI || (state_reg == ST_PASS && out_free))
            begin
                if (!ch_is_last) ch_reg <= ch_reg + CW'(1);
                if (emit_x) any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
            item_reg <= cmd_item;
    end

    // Result register; the non-transfer result is built on the idle cycle
    logic [31:0] rd_hold_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
            rd_hold_reg <= (cmd_item.cmd == CMD_READ) ? rd_val : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg <= emit_x || state_reg == ST_OUT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            oirq0_reg <= ((32'(irq_n) & en0_n) | frc0_n) != 32'd0;
            oirq1_reg <= ((32'(irq_n) & en1_n) | frc1_n) != 32'd0;
            if (emit_x)
            begin
                rd_reg    <= 32'd0;
                oxv_reg   <= 1'b1;
                och_reg   <= 4'(ch_reg);
                osrc_reg  <= src_reg[ch_reg];
                odst_reg  <= dst_reg[ch_reg];
                ocode_reg <= ccode;
                olast_reg <= !more_after;
            end
            else
            begin
                rd_reg    <= rd_hold_reg;
                oxv_reg   <= 1'b0;
                och_reg   <= 4'd0;
                osrc_reg  <= 32'd0;
                odst_reg  <= 32'd0;
                ocode_reg <= 2'd0;
                olast_reg <= 1'b1;
            end
        end
    end
endmodule

[hdl/multichannel_dma_controller.sv]
// Multichannel DMA controller top: front queue feeding the channel engine.
// Read/write: accepted in idle, then through the output state to the result register; no
// new command is taken until back in idle. Service pass: one channel per cycle, a stalled
// output holding the walker, then the output state only when nothing moves. Multi-channel
// trigger: each channel in turn, then output. Async active-low reset clears control state.
// Depends on mdc_pkg, mdc_cmd_fifo and mdc_engine.
module multichannel_dma_controller #(
    parameter int NUM_CHANNELS = mdc_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [13:0] offset,
    input  logic [31:0] write_data,
    input  logic        spi_tx_ready,
    input  logic        spi_rx_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        xfer_valid,
    output logic [3:0]  xfer_channel,
    output logic [31:0] xfer_source,
    output logic [31:0] xfer_dest,
    output logic [1:0]  xfer_size_code,
    output logic        irq_line0,
    output logic        irq_line1,
    output logic        last
);
    import mdc_pkg::*;

    cmd_item_t in_item, q_item;
    logic      q_valid, q_ready;

    // Front: classify command and queue
    always_comb
    begin
        in_item.cmd    = cmd_t'(command);
        in_item.offset = offset;
        in_item.wdata  = write_data;
        in_item.tx_ok  = spi_tx_ready;
        in_item.rx_ok  = spi_rx_ready;
    end

    mdc_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    mdc_engine #(.NUM_CHANNELS(NUM_CHANNELS)) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd_item       (q_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .xfer_valid     (xfer_valid),
        .xfer_channel   (xfer_channel),
        .xfer_source    (xfer_source),
        .xfer_dest      (xfer_dest),
        .xfer_size_code (xfer_size_code),
        .irq_line0      (irq_line0),
        .irq_line1      (irq_line1),
        .last           (last)
    );

    // A transfer result never carries read data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && xfer_valid |-> read_data == 32'd0)
        else $error("transfer result with read data");

    // Channel of a transfer stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && xfer_valid |-> int'(xfer_channel) < NUM_CHANNELS)
        else $error("transfer channel out of range");

    // Non-transfer results are always final
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !xfer_valid |-> last)
        else $error("non-transfer result not marked last");
endmodule
